// ===== design/tribc_pkg.sv =====
// ----------------------------------------------------------------------------
// tribc_pkg
// Shared widths and limits for the triangle barycentric pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package tribc_pkg;

    // input coordinate and difference widths
    localparam int CW   = 16;
    localparam int DFW  = CW + 1;
    // cross product partial products and components
    localparam int PW   = 2 * DFW;
    localparam int XW   = PW + 1;
    // dot product partial products and sums
    localparam int SW   = 2 * XW;
    localparam int DW   = SW + 2;
    localparam int NW   = DW + 2;
    localparam int MW   = NW;
    // quotient and fraction bits
    localparam int FB   = 16;
    localparam int QB   = 24;
    localparam int RW   = DW + QB;
    localparam int EPSW = 17;
    // pipeline stages: six front stages, one per quotient bit, one output
    localparam int DIV0 = 7;
    localparam int NST  = DIV0 + QB;

    localparam logic signed [QB-1:0] WMAX = {1'b0, {(QB-1){1'b1}}};
    localparam logic signed [QB-1:0] WMIN = {1'b1, {(QB-1){1'b0}}};

endpackage : tribc_pkg

`default_nettype wire

// ===== design/tribc_div.sv =====
// ----------------------------------------------------------------------------
// tribc_div
// Three-lane restoring divider, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tribc_div (
    input  wire logic                                   clk,
    input  wire logic [tribc_pkg::QB-1:0]               en,
    input  wire logic [tribc_pkg::DW-1:0]               den,
    input  wire logic [2:0][tribc_pkg::MW-1:0]          mag,
    output logic      [2:0][tribc_pkg::QB-1:0]          quot
);

    logic [tribc_pkg::DW-1:0]          d_reg [tribc_pkg::QB];
    logic [2:0][tribc_pkg::RW-1:0]     r_reg [tribc_pkg::QB];
    logic [2:0][tribc_pkg::QB-1:0]     q_reg [tribc_pkg::QB];

    genvar j, l;
    generate
        for (j = 0; j < tribc_pkg::QB; j++)
        begin : g_step
            localparam int K = tribc_pkg::QB - 1 - j;
            logic [tribc_pkg::DW-1:0]      d_in;
            logic [2:0][tribc_pkg::RW-1:0] r_in;
            logic [2:0][tribc_pkg::QB-1:0] q_in;
            logic [2:0][tribc_pkg::RW-1:0] r_next;
            logic [2:0][tribc_pkg::QB-1:0] q_next;
            logic [tribc_pkg::RW-1:0]      trial;

            // stage inputs: divisor and magnitudes on entry, previous stage otherwise
            if (j == 0)
            begin : g_first
                assign d_in = den;
                for (l = 0; l < 3; l++)
                begin : g_lane
                    assign r_in[l] = tribc_pkg::RW'(mag[l]) << tribc_pkg::FB;
                    assign q_in[l] = '0;
                end
            end
            else
            begin : g_rest
                assign d_in = d_reg[j-1];
                assign r_in = r_reg[j-1];
                assign q_in = q_reg[j-1];
            end

            assign trial = tribc_pkg::RW'(d_in) << K;

            // trial subtract for this quotient bit
            for (l = 0; l < 3; l++)
            begin : g_sub
                always_comb
                begin
                    r_next[l] = r_in[l];
                    q_next[l] = q_in[l];
                    if (r_in[l] >= trial)
                    begin
                        r_next[l]    = r_in[l] - trial;
                        q_next[l][K] = 1'b1;
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (en[j])
                begin
                    d_reg[j] <= d_in;
                    r_reg[j] <= r_next;
                    q_reg[j] <= q_next;
                end
            end
        end
    endgenerate

    assign quot = q_reg[tribc_pkg::QB-1];

endmodule : tribc_div

`default_nettype wire

// ===== design/triangle_barycentric.sv =====
// Throughput: one transaction per cycle while the output is not stalled; the
// 24-stage divider takes one quotient bit a stage.
// A stalled output holds its stage; emptier stages upstream keep filling behind it.
// Reset clears all valid bits and sets the tolerance register eps_reg to zero.
// ----------------------------------------------------------------------------
// triangle_barycentric
// Pipelined barycentric weights of a point against a triangle in Q8.16.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_barycentric (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              eps_we,
    input  wire logic [tribc_pkg::EPSW-1:0]        eps_data,
    input  wire logic                              item_valid,
    output logic                                   item_stall,
    input  wire logic signed [tribc_pkg::CW-1:0]   point_x,
    input  wire logic signed [tribc_pkg::CW-1:0]   point_y,
    input  wire logic signed [tribc_pkg::CW-1:0]   point_z,
    input  wire logic signed [tribc_pkg::CW-1:0]   vert_a_x,
    input  wire logic signed [tribc_pkg::CW-1:0]   vert_a_y,
    input  wire logic signed [tribc_pkg::CW-1:0]   vert_a_z,
    input  wire logic signed [tribc_pkg::CW-1:0]   vert_b_x,
    input  wire logic signed [tribc_pkg::CW-1:0]   vert_b_y,
    input  wire logic signed [tribc_pkg::CW-1:0]   vert_b_z,
    input  wire logic signed [tribc_pkg::CW-1:0]   vert_c_x,
    input  wire logic signed [tribc_pkg::CW-1:0]   vert_c_y,
    input  wire logic signed [tribc_pkg::CW-1:0]   vert_c_z,
    output logic                                   result_valid,
    input  wire logic                              result_stall,
    output logic signed [tribc_pkg::QB-1:0]        weight_u,
    output logic signed [tribc_pkg::QB-1:0]        weight_v,
    output logic signed [tribc_pkg::QB-1:0]        weight_w,
    output logic                                   inside_res,
    output logic                                   degenerate
);

    typedef struct packed {
        logic [2:0] neg;
        logic [2:0] sat;
        logic       degen;
    } side_t;

    logic [tribc_pkg::EPSW-1:0] eps_reg;
    logic [tribc_pkg::NST:1]    v_reg;
    logic [tribc_pkg::NST+1:1]  en;

    logic signed [tribc_pkg::CW-1:0] pt [3];
    logic signed [tribc_pkg::CW-1:0] va [3];
    logic signed [tribc_pkg::CW-1:0] vb [3];
    logic signed [tribc_pkg::CW-1:0] vc [3];

    logic signed [tribc_pkg::DFW-1:0] ab_reg [3];
    logic signed [tribc_pkg::DFW-1:0] ac_reg [3];
    logic signed [tribc_pkg::DFW-1:0] pb_reg [3];
    logic signed [tribc_pkg::DFW-1:0] pc_reg [3];
    logic signed [tribc_pkg::DFW-1:0] pa_reg [3];

    logic signed [tribc_pkg::PW-1:0] pn1_reg [3];
    logic signed [tribc_pkg::PW-1:0] pn2_reg [3];
    logic signed [tribc_pkg::PW-1:0] pu1_reg [3];
    logic signed [tribc_pkg::PW-1:0] pu2_reg [3];
    logic signed [tribc_pkg::PW-1:0] pv1_reg [3];
    logic signed [tribc_pkg::PW-1:0] pv2_reg [3];

    logic signed [tribc_pkg::XW-1:0] n_reg  [3];
    logic signed [tribc_pkg::XW-1:0] cu_reg [3];
    logic signed [tribc_pkg::XW-1:0] cv_reg [3];

    logic signed [tribc_pkg::SW-1:0] dd_reg [3];
    logic signed [tribc_pkg::SW-1:0] du_reg [3];
    logic signed [tribc_pkg::SW-1:0] dv_reg [3];

    logic signed [tribc_pkg::DW-1:0] den_reg;
    logic signed [tribc_pkg::DW-1:0] nu_reg;
    logic signed [tribc_pkg::DW-1:0] nv_reg;

    logic signed [tribc_pkg::NW-1:0]   num [3];
    logic [2:0][tribc_pkg::MW-1:0]     mag_next;
    logic [2:0][tribc_pkg::MW-1:0]     mag_reg;
    logic [tribc_pkg::DW-1:0]          dq_reg;
    side_t                             side_next;
    side_t                             s6_reg;
    side_t                             side_reg [tribc_pkg::QB];
    logic [2:0][tribc_pkg::QB-1:0]     quot;

    logic signed [tribc_pkg::QB-1:0]   wt_next [3];
    logic                              inside_next;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg <= '0;
        end
        else if (eps_we)
        begin
            eps_reg <= eps_data;
        end
    end

    // stage enables: a stage loads when empty or when the next one moves
    always_comb
    begin
        en[tribc_pkg::NST+1] = !result_stall;
        for (int i = tribc_pkg::NST; i >= 1; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    assign item_stall = !en[1];

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[1])
            begin
                v_reg[1] <= item_valid;
            end
            for (int i = 2; i <= tribc_pkg::NST; i++)
            begin
                if (en[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    assign pt = '{point_x, point_y, point_z};
    assign va = '{vert_a_x, vert_a_y, vert_a_z};
    assign vb = '{vert_b_x, vert_b_y, vert_b_z};
    assign vc = '{vert_c_x, vert_c_y, vert_c_z};

    // stage 1: edge and point differences
    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            for (int i = 0; i < 3; i++)
            begin
                ab_reg[i] <= tribc_pkg::DFW'(vb[i]) - tribc_pkg::DFW'(va[i]);
                ac_reg[i] <= tribc_pkg::DFW'(vc[i]) - tribc_pkg::DFW'(va[i]);
                pb_reg[i] <= tribc_pkg::DFW'(vb[i]) - tribc_pkg::DFW'(pt[i]);
                pc_reg[i] <= tribc_pkg::DFW'(vc[i]) - tribc_pkg::DFW'(pt[i]);
                pa_reg[i] <= tribc_pkg::DFW'(va[i]) - tribc_pkg::DFW'(pt[i]);
            end
        end
    end

    // stage 2: cross product partial products
    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            for (int i = 0; i < 3; i++)
            begin
                pn1_reg[i] <= ab_reg[(i+1)%3] * ac_reg[(i+2)%3];
                pn2_reg[i] <= ab_reg[(i+2)%3] * ac_reg[(i+1)%3];
                pu1_reg[i] <= pb_reg[(i+1)%3] * pc_reg[(i+2)%3];
                pu2_reg[i] <= pb_reg[(i+2)%3] * pc_reg[(i+1)%3];
                pv1_reg[i] <= pc_reg[(i+1)%3] * pa_reg[(i+2)%3];
                pv2_reg[i] <= pc_reg[(i+2)%3] * pa_reg[(i+1)%3];
            end
        end
    end

    // stage 3: cross product components
    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            for (int i = 0; i < 3; i++)
            begin
                n_reg[i]  <= tribc_pkg::XW'(pn1_reg[i]) - tribc_pkg::XW'(pn2_reg[i]);
                cu_reg[i] <= tribc_pkg::XW'(pu1_reg[i]) - tribc_pkg::XW'(pu2_reg[i]);
                cv_reg[i] <= tribc_pkg::XW'(pv1_reg[i]) - tribc_pkg::XW'(pv2_reg[i]);
            end
        end
    end

    // stage 4: dot product partial products against the normal
    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            for (int i = 0; i < 3; i++)
            begin
                dd_reg[i] <= n_reg[i] * n_reg[i];
                du_reg[i] <= cu_reg[i] * n_reg[i];
                dv_reg[i] <= cv_reg[i] * n_reg[i];
            end
        end
    end

    // stage 5: squared normal length and the two numerators
    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            den_reg <= tribc_pkg::DW'(dd_reg[0]) + tribc_pkg::DW'(dd_reg[1])
                     + tribc_pkg::DW'(dd_reg[2]);
            nu_reg  <= tribc_pkg::DW'(du_reg[0]) + tribc_pkg::DW'(du_reg[1])
                     + tribc_pkg::DW'(du_reg[2]);
            nv_reg  <= tribc_pkg::DW'(dv_reg[0]) + tribc_pkg::DW'(dv_reg[1])
                     + tribc_pkg::DW'(dv_reg[2]);
        end
    end

    // stage 6: third numerator, magnitudes, signs and saturation flags
    always_comb
    begin
        num[0] = tribc_pkg::NW'(nu_reg);
        num[1] = tribc_pkg::NW'(nv_reg);
        num[2] = tribc_pkg::NW'(den_reg) - tribc_pkg::NW'(nu_reg) - tribc_pkg::NW'(nv_reg);
        side_next.degen = (den_reg == '0);
        for (int i = 0; i < 3; i++)
        begin
            side_next.neg[i] = num[i][tribc_pkg::NW-1];
            mag_next[i]      = side_next.neg[i] ? tribc_pkg::MW'(-num[i])
                                                : tribc_pkg::MW'(num[i]);
            side_next.sat[i] = tribc_pkg::RW'(mag_next[i])
                               >= (tribc_pkg::RW'(den_reg) << 8);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            mag_reg <= mag_next;
            dq_reg  <= den_reg;
            s6_reg  <= side_next;
        end
    end

    // stages 7 to 30: one quotient bit per stage
    tribc_div u_div (
        .clk  (clk),
        .en   (en[tribc_pkg::NST-1:tribc_pkg::DIV0]),
        .den  (dq_reg),
        .mag  (mag_reg),
        .quot (quot)
    );

    always_ff @(posedge clk)
    begin
        if (en[tribc_pkg::DIV0])
        begin
            side_reg[0] <= s6_reg;
        end
        for (int j = 1; j < tribc_pkg::QB; j++)
        begin
            if (en[tribc_pkg::DIV0+j])
            begin
                side_reg[j] <= side_reg[j-1];
            end
        end
    end

    // output stage: sign, clamp and tolerance band test
    always_comb
    begin
        side_t sd;
        logic signed [tribc_pkg::QB+1:0] lo;
        logic signed [tribc_pkg::QB+1:0] hi;
        logic signed [tribc_pkg::QB+1:0] w_ext;
        sd          = side_reg[tribc_pkg::QB-1];
        lo          = -$signed({9'b0, eps_reg});
        hi          = $signed({9'b0, eps_reg}) + (26'sd1 <<< tribc_pkg::FB);
        inside_next = !sd.degen;
        for (int i = 0; i < 3; i++)
        begin
            if (sd.sat[i] || quot[i][tribc_pkg::QB-1])
            begin
                wt_next[i] = sd.neg[i] ? tribc_pkg::WMIN : tribc_pkg::WMAX;
            end
            else
            begin
                wt_next[i] = sd.neg[i] ? -$signed(quot[i]) : $signed(quot[i]);
            end
            if (sd.degen)
            begin
                wt_next[i] = '0;
            end
            w_ext = {{2{wt_next[i][tribc_pkg::QB-1]}}, wt_next[i]};
            if (w_ext < lo || w_ext > hi)
            begin
                inside_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[tribc_pkg::NST])
        begin
            weight_u   <= wt_next[0];
            weight_v   <= wt_next[1];
            weight_w   <= wt_next[2];
            inside_res <= inside_next;
            degenerate <= side_reg[tribc_pkg::QB-1].degen;
        end
    end

    assign result_valid = v_reg[tribc_pkg::NST];

    // a degenerate triangle gives zero weights and is never inside
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && degenerate |->
            weight_u == '0 && weight_v == '0 && weight_w == '0 && !inside_res)
        else $error("degenerate result with nonzero weights or inside set");

    // the input is held back only when every stage is full
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> &v_reg)
        else $error("input stalled with an empty pipeline stage");

    // the input is held back only while the output is held back
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_stall)
        else $error("input stalled without output stall");

    // an item in the output register that cannot leave stays there
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("stalled result lost");

endmodule : triangle_barycentric

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for triangle_barycentric. A predictor works out each
// transaction's weights, inside flag and degenerate flag with wide exact
// integers, and a monitor compares every accepted result against the oldest
// expectation. Both channels idle at random, and the tolerance register is
// changed between phases only while the pipeline is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

    typedef logic signed [tribc_pkg::CW-1:0]  coord_t;
    typedef logic signed [127:0]   big_t;
    typedef coord_t                query_t [12];

    typedef struct packed {
        logic signed [tribc_pkg::QB-1:0] u;
        logic signed [tribc_pkg::QB-1:0] v;
        logic signed [tribc_pkg::QB-1:0] w;
        logic                 ins;
        logic                 deg;
    } weights_t;

    localparam int PIPE_CYCLES = 40;
    localparam int WATCHDOG    = 3000;

    logic                clk;
    logic                rst_n;
    logic                eps_we;
    logic [tribc_pkg::EPSW-1:0] eps_data;
    logic                item_valid;
    logic                item_stall;
    logic                result_valid;
    logic                result_stall;
    logic signed [tribc_pkg::QB-1:0] weight_u, weight_v, weight_w;
    logic                inside_res;
    logic                degenerate;
    coord_t              drv [12];

    // shadow copy of the tolerance register
    logic [tribc_pkg::EPSW-1:0] eps_shadow;
    weights_t            expected_weights [$];
    int                  err_count;
    int                  sent_count;
    int                  got_count;
    int                  degen_count;
    int                  inside_count;
    int                  idle_cycles = 0;
    bit                  quiet;
    int                  stall_left;

    triangle_barycentric u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .eps_we       (eps_we),
        .eps_data     (eps_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .point_x      (drv[0]),
        .point_y      (drv[1]),
        .point_z      (drv[2]),
        .vert_a_x     (drv[3]),
        .vert_a_y     (drv[4]),
        .vert_a_z     (drv[5]),
        .vert_b_x     (drv[6]),
        .vert_b_y     (drv[7]),
        .vert_b_z     (drv[8]),
        .vert_c_x     (drv[9]),
        .vert_c_y     (drv[10]),
        .vert_c_z     (drv[11]),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .weight_u     (weight_u),
        .weight_v     (weight_v),
        .weight_w     (weight_w),
        .inside_res   (inside_res),
        .degenerate   (degenerate)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // weight times 2^16, truncated toward zero, clamped to 24 bits
    function automatic logic signed [tribc_pkg::QB-1:0] to_q8_16(big_t num, big_t den);
        logic [127:0] mag;
        logic [127:0] q;
        mag = num[127] ? -num : num;
        q   = (mag << tribc_pkg::FB) / den;
        if (num[127])
            return (q > 128'd8388608) ? tribc_pkg::WMIN : -q[tribc_pkg::QB-1:0];
        return (q > 128'd8388607) ? tribc_pkg::WMAX : q[tribc_pkg::QB-1:0];
    endfunction

    function automatic weights_t barycentric(query_t q, logic [tribc_pkg::EPSW-1:0] eps);
        big_t     p [3], ab [3], ac [3], bp [3], cp [3], ap [3];
        big_t     n [3], cu [3], cv [3];
        big_t     den, nu, nv, nw, lo, hi;
        weights_t r;
        for (int i = 0; i < 3; i++)
        begin
            p[i]  = q[i];
            ab[i] = big_t'(q[6 + i]) - big_t'(q[3 + i]);
            ac[i] = big_t'(q[9 + i]) - big_t'(q[3 + i]);
            bp[i] = big_t'(q[6 + i]) - p[i];
            cp[i] = big_t'(q[9 + i]) - p[i];
            ap[i] = big_t'(q[3 + i]) - p[i];
        end
        for (int i = 0; i < 3; i++)
        begin
            n[i]  = ab[(i+1)%3] * ac[(i+2)%3] - ab[(i+2)%3] * ac[(i+1)%3];
            cu[i] = bp[(i+1)%3] * cp[(i+2)%3] - bp[(i+2)%3] * cp[(i+1)%3];
            cv[i] = cp[(i+1)%3] * ap[(i+2)%3] - cp[(i+2)%3] * ap[(i+1)%3];
        end
        den = n[0] * n[0] + n[1] * n[1] + n[2] * n[2];
        r   = '0;
        if (den == 0)
        begin
            r.deg = 1'b1;
            return r;
        end
        nu  = cu[0] * n[0] + cu[1] * n[1] + cu[2] * n[2];
        nv  = cv[0] * n[0] + cv[1] * n[1] + cv[2] * n[2];
        nw  = den - nu - nv;
        r.u = to_q8_16(nu, den);
        r.v = to_q8_16(nv, den);
        r.w = to_q8_16(nw, den);
        lo  = -big_t'(eps);
        hi  = big_t'(65536) + big_t'(eps);
        r.ins = big_t'(r.u) >= lo && big_t'(r.u) <= hi &&
                big_t'(r.v) >= lo && big_t'(r.v) <= hi &&
                big_t'(r.w) >= lo && big_t'(r.w) <= hi;
        return r;
    endfunction

    // drive one transaction, wait for acceptance, then an optional gap
    task automatic send_query(query_t q);
        int gap;
        @(negedge clk);
        for (int i = 0; i < 12; i++)
            drv[i] = q[i];
        item_valid = 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        expected_weights.push_back(barycentric(q, eps_shadow));
        sent_count++;
        gap = quiet ? 0 : pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            item_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic wait_drained();
        while (expected_weights.size() != 0)
            @(posedge clk);
        repeat (PIPE_CYCLES) @(posedge clk);
    endtask

    // register writes happen only with the pipeline empty
    task automatic write_eps(logic [tribc_pkg::EPSW-1:0] val);
        @(negedge clk);
        item_valid = 1'b0;
        wait_drained();
        @(negedge clk);
        eps_we   = 1'b1;
        eps_data = val;
        @(negedge clk);
        eps_we   = 1'b0;
        eps_shadow = val;
    endtask

    function automatic query_t make_query(coord_t px, coord_t py, coord_t pz,
                                          coord_t ax, coord_t ay, coord_t az,
                                          coord_t bx, coord_t by, coord_t bz,
                                          coord_t cx, coord_t cy, coord_t cz);
        query_t q;
        q = '{px, py, pz, ax, ay, az, bx, by, bz, cx, cy, cz};
        return q;
    endfunction

    function automatic coord_t rnd_small(int span);
        return coord_t'($urandom_range(0, 2 * span) - span);
    endfunction

    // random query drawn from a mix of shapes
    function automatic query_t random_query();
        query_t q;
        int     kind;
        int     k;
        kind = $urandom_range(0, 99);
        for (int i = 0; i < 12; i++)
            q[i] = coord_t'($urandom());
        if (kind < 45)
        begin
            // compact triangle with the point nearby, weights mostly in range
            for (int i = 3; i < 12; i++)
                q[i] = rnd_small(600);
            for (int i = 0; i < 3; i++)
                q[i] = coord_t'((int'(q[3+i]) + int'(q[6+i]) + int'(q[9+i])) / 3
                                + int'(rnd_small(300)));
        end
        else if (kind < 55)
        begin
            // collinear or coincident vertices
            k = int'($urandom_range(0, 4)) - 2;
            for (int i = 0; i < 3; i++)
            begin
                q[3+i] = rnd_small(4000);
                q[6+i] = rnd_small(4000);
                q[9+i] = coord_t'(int'(q[3+i]) + k * (int'(q[6+i]) - int'(q[3+i])));
            end
        end
        else if (kind < 62)
        begin
            // point on a vertex
            k = $urandom_range(1, 3);
            for (int i = 0; i < 3; i++)
                q[i] = q[3 * k + i];
        end
        else if (kind < 70)
        begin
            // tiny triangle against a far point, weights saturate
            for (int i = 3; i < 12; i++)
                q[i] = rnd_small(3);
        end
        return q;
    endfunction

    task automatic test_directed();
        coord_t mx, mn;
        mx = 16'sh7fff;
        mn = 16'sh8000;
        // all extremes give degenerate triangles
        send_query(make_query(mn, mn, mn, mn, mn, mn, mn, mn, mn, mn, mn, mn));
        send_query(make_query(mx, mx, mx, mx, mx, mx, mx, mx, mx, mx, mx, mx));
        send_query(make_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        // collinear vertices
        send_query(make_query(5, 5, 5, 0, 0, 0, 256, 256, 256, 512, 512, 512));
        // unit triangle: point on each vertex, centroid, edge, outside
        send_query(make_query(0, 0, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0));
        send_query(make_query(256, 0, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0));
        send_query(make_query(0, 256, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0));
        send_query(make_query(85, 85, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0));
        send_query(make_query(128, 128, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0));
        send_query(make_query(-1, -1, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0));
        send_query(make_query(300, 300, 77, 0, 0, 0, 256, 0, 0, 0, 256, 0));
        // largest triangle across the full range
        send_query(make_query(0, 0, 0, mn, mn, mn, mx, mn, mx, mn, mx, mx));
        send_query(make_query(mx, mx, mx, mn, mn, mn, mx, mn, mx, mn, mx, mx));
        send_query(make_query(mn, mx, mn, mx, mx, mn, mn, mn, mx, mx, mn, mn));
        // tiny triangle and far point: positive and negative saturation
        send_query(make_query(mx, mx, 0, 0, 0, 0, 1, 0, 0, 0, 1, 0));
        send_query(make_query(mn, mn, mn, 0, 0, 0, 1, 0, 0, 0, 1, 0));
        send_query(make_query(mx, mn, mx, 0, 0, 0, 0, 0, 1, 1, 0, 0));
        // negative coordinates everywhere
        send_query(make_query(-300, -300, -300, -256, -256, -256, -512, -256, -256,
                              -256, -512, -300));
    endtask

    task automatic test_tolerance();
        logic [tribc_pkg::EPSW-1:0] settings [4];
        settings = '{17'd65536, 17'd1, 17'd6553,
                     tribc_pkg::EPSW'($urandom_range(0, 65536))};
        foreach (settings[s])
        begin
            write_eps(settings[s]);
            // points just around the edges of a unit triangle
            repeat (60)
                send_query(make_query(rnd_small(300), rnd_small(300), rnd_small(20),
                                      0, 0, 0, 256, 0, 0, 0, 256, 0));
            repeat (60)
                send_query(random_query());
        end
    endtask

    task automatic test_random();
        for (int i = 0; i < 1400; i++)
        begin
            // stretches with no idling on the sender or the receiver
            if (i % 200 == 0)
                quiet = (i % 400 == 200);
            if (i == 700)
            begin
                @(negedge clk);
                item_valid = 1'b0;
                while (expected_weights.size() != 0)
                    @(posedge clk);
            end
            send_query(random_query());
        end
        quiet = 1'b0;
        write_eps(17'd0);
        repeat (20)
            send_query(random_query());
    endtask

    // receiver stall pattern
    always @(negedge clk)
    begin
        if (quiet || !rst_n)
        begin
            result_stall <= 1'b0;
            stall_left   <= 0;
        end
        else if (stall_left > 0)
        begin
            result_stall <= 1'b1;
            stall_left   <= stall_left - 1;
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            result_stall <= 1'b1;
            stall_left   <= pick_gap();
        end
        else
        begin
            result_stall <= 1'b0;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        weights_t exp_w;
        if (rst_n && result_valid && !result_stall)
        begin
            got_count++;
            if (expected_weights.size() == 0)
            begin
                $error("result transaction with nothing expected");
                err_count++;
            end
            else
            begin
                exp_w = expected_weights.pop_front();
                if (exp_w.deg)
                    degen_count++;
                if (exp_w.ins)
                    inside_count++;
                if (weight_u !== exp_w.u)
                begin
                    $error("weight_u expected %0d got %0d", exp_w.u, weight_u);
                    err_count++;
                end
                if (weight_v !== exp_w.v)
                begin
                    $error("weight_v expected %0d got %0d", exp_w.v, weight_v);
                    err_count++;
                end
                if (weight_w !== exp_w.w)
                begin
                    $error("weight_w expected %0d got %0d", exp_w.w, weight_w);
                    err_count++;
                end
                if (inside_res !== exp_w.ins)
                begin
                    $error("inside_res expected %0b got %0b", exp_w.ins, inside_res);
                    err_count++;
                end
                if (degenerate !== exp_w.deg)
                begin
                    $error("degenerate expected %0b got %0b", exp_w.deg, degenerate);
                    err_count++;
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        rst_n      = 1'b0;
        eps_we     = 1'b0;
        eps_data   = '0;
        item_valid = 1'b0;
        for (int i = 0; i < 12; i++)
            drv[i] = '0;
        eps_shadow  = '0;
        err_count   = 0;
        sent_count  = 0;
        got_count   = 0;
        degen_count = 0;
        inside_count = 0;
        quiet       = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_tolerance();
        test_random();

        @(negedge clk);
        item_valid = 1'b0;
        wait_drained();

        $display("covered %0d transactions in, %0d results out", sent_count, got_count);
        $display("%0d degenerate, %0d inside, tolerance swept 0 to 65536",
                 degen_count, inside_count);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
